FILE: rtl/cgc_pkg.sv
package cgc_pkg;

  localparam int HEAP_NODES = 64;
  localparam int ADDR_BASE  = 100;
  localparam int HALF_NODES = HEAP_NODES / 2;
  localparam int IDX_W      = $clog2(HEAP_NODES);
  localparam int CNT_W      = IDX_W + 1;
  localparam int ADDR_W     = 12;
  localparam int VAL_W      = 8;

  localparam logic [2:0] CMD_ALLOC   = 3'd0;
  localparam logic [2:0] CMD_READ    = 3'd1;
  localparam logic [2:0] CMD_WRITE   = 3'd2;
  localparam logic [2:0] CMD_ROOT    = 3'd3;
  localparam logic [2:0] CMD_COLLECT = 3'd4;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_NULL = 2'd1;
  localparam logic [1:0] ST_SEGV = 2'd2;
  localparam logic [1:0] ST_OOM  = 2'd3;

  typedef struct packed {
    logic [2:0]        cmd;
    logic [VAL_W-1:0]  node_value;
    logic [ADDR_W-1:0] left_addr;
    logic [ADDR_W-1:0] right_addr;
    logic [ADDR_W-1:0] target_addr;
  } in_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [ADDR_W-1:0] result_addr;
    logic [VAL_W-1:0]  out_value;
    logic [ADDR_W-1:0] out_left;
    logic [ADDR_W-1:0] out_right;
  } out_t;

  typedef struct packed {
    logic [VAL_W-1:0]  value;
    logic [ADDR_W-1:0] left;
    logic [ADDR_W-1:0] right;
  } node_t;

  localparam int NODE_W = $bits(node_t);

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    node_t            wdata;
    logic             re;
    logic [IDX_W-1:0] raddr;
  } mem_req_t;

  typedef struct packed {
    logic             in_heap;
    logic             in_half;
    logic [IDX_W-1:0] idx;
  } ptr_t;

endpackage

FILE: rtl/copying_garbage_collector.sv
// Channel | Direction | Payload            | Handshake
// in      | input     | cgc_pkg::in_t      | in_valid, in_stall
// out     | output    | cgc_pkg::out_t     | out_valid, out_stall
//
// Read, write, set root and unused commands pass the execute state to the result; a read
// also waits in the read-wait state, and allocate without collection in the allocate state.
// A collection adds a state to swap halves, then forwards each pointer and scans each copied
// node, all serialized on the single read port and single write port of the node RAM.
// Reset clears the sequencer, allocation index, half select and root; heap contents
// stay undefined until written, with no clearing pass.
// in_stall is high from the cycle after a transfer until the sequencer is idle again;
// the output register holds one result, so the next item can be taken while it waits.
module copying_garbage_collector (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  cgc_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output cgc_pkg::out_t out_data
);

  logic              busy;
  logic              done_valid;
  logic              done_ready;
  cgc_pkg::out_t     done_data;
  cgc_pkg::mem_req_t mem;
  cgc_pkg::node_t    rdata;

  assign in_stall   = busy;
  assign done_ready = !out_valid || !out_stall;

  cgc_seq u_seq (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_data    (in_data),
    .busy       (busy),
    .done_valid (done_valid),
    .done_ready (done_ready),
    .done_data  (done_data),
    .mem        (mem),
    .rdata      (rdata)
  );

  cgc_ram #(
    .WIDTH (cgc_pkg::NODE_W),
    .DEPTH (cgc_pkg::HEAP_NODES)
  ) u_ram (
    .clk   (clk),
    .we    (mem.we),
    .waddr (mem.waddr),
    .wdata (mem.wdata),
    .re    (mem.re),
    .raddr (mem.raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (done_valid && done_ready) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done_valid && done_ready) begin
      out_data <= done_data;
    end
  end

endmodule

FILE: rtl/cgc_ram.sv
module cgc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/cgc_ptr.sv
module cgc_ptr (
  input  logic [cgc_pkg::ADDR_W-1:0] addr,
  input  logic [cgc_pkg::CNT_W-1:0]  lo,
  output cgc_pkg::ptr_t              res
);

  logic [cgc_pkg::ADDR_W-1:0] diff;
  logic [cgc_pkg::ADDR_W-1:0] lo_ext;
  logic [cgc_pkg::ADDR_W-1:0] hi_ext;

  assign diff   = addr - cgc_pkg::ADDR_W'(cgc_pkg::ADDR_BASE);
  assign lo_ext = cgc_pkg::ADDR_W'(lo);
  assign hi_ext = lo_ext + cgc_pkg::ADDR_W'(cgc_pkg::HALF_NODES);

  always_comb begin
    res.in_heap = (addr >= cgc_pkg::ADDR_W'(cgc_pkg::ADDR_BASE)) &&
                  (diff < cgc_pkg::ADDR_W'(cgc_pkg::HEAP_NODES));
    res.in_half = res.in_heap && (diff >= lo_ext) && (diff < hi_ext);
    res.idx     = diff[cgc_pkg::IDX_W-1:0];
  end

endmodule

FILE: rtl/cgc_seq.sv
module cgc_seq (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  cgc_pkg::in_t       in_data,
  output logic               busy,
  output logic               done_valid,
  input  logic               done_ready,
  output cgc_pkg::out_t      done_data,
  output cgc_pkg::mem_req_t  mem,
  input  cgc_pkg::node_t     rdata
);

  localparam logic [3:0] S_IDLE      = 4'd0;
  localparam logic [3:0] S_EXEC      = 4'd1;
  localparam logic [3:0] S_RD_WAIT   = 4'd2;
  localparam logic [3:0] S_ALLOC     = 4'd3;
  localparam logic [3:0] S_GC_START  = 4'd4;
  localparam logic [3:0] S_FWD_START = 4'd5;
  localparam logic [3:0] S_FWD_CHK   = 4'd6;
  localparam logic [3:0] S_FWD_MARK  = 4'd7;
  localparam logic [3:0] S_FWD_RET   = 4'd8;
  localparam logic [3:0] S_SCAN_CHK  = 4'd9;
  localparam logic [3:0] S_SCAN_RD   = 4'd10;
  localparam logic [3:0] S_SL_WR     = 4'd11;
  localparam logic [3:0] S_SR_WR     = 4'd12;
  localparam logic [3:0] S_DONE      = 4'd13;

  localparam logic [2:0] RET_ROOT  = 3'd0;
  localparam logic [2:0] RET_L     = 3'd1;
  localparam logic [2:0] RET_R     = 3'd2;
  localparam logic [2:0] RET_SCANL = 3'd3;
  localparam logic [2:0] RET_SCANR = 3'd4;

  logic [3:0]                 state;
  logic [2:0]                 cmd;
  logic [cgc_pkg::VAL_W-1:0]  val;
  logic [cgc_pkg::ADDR_W-1:0] l;
  logic [cgc_pkg::ADDR_W-1:0] r;
  logic [cgc_pkg::ADDR_W-1:0] t;
  logic [cgc_pkg::CNT_W-1:0]  alloc_index;
  logic                       active_half;
  logic [cgc_pkg::ADDR_W-1:0] root_addr;
  logic [cgc_pkg::CNT_W-1:0]  scan;
  logic [cgc_pkg::ADDR_W-1:0] fa;
  logic [cgc_pkg::IDX_W-1:0]  fidx;
  logic [cgc_pkg::ADDR_W-1:0] fres;
  logic [2:0]                 fret;
  cgc_pkg::out_t              rslt;

  logic [cgc_pkg::CNT_W-1:0]  lo;
  logic [cgc_pkg::CNT_W-1:0]  lo_swap;
  logic [cgc_pkg::CNT_W-1:0]  hi;
  logic                       full;
  logic                       oom;
  logic                       scan_more;
  logic [cgc_pkg::ADDR_W-1:0] new_addr;
  logic [cgc_pkg::ADDR_W-1:0] ptr_addr;
  cgc_pkg::ptr_t              p;

  assign lo        = active_half ? cgc_pkg::CNT_W'(cgc_pkg::HALF_NODES) : '0;
  assign lo_swap   = active_half ? '0 : cgc_pkg::CNT_W'(cgc_pkg::HALF_NODES);
  assign hi        = lo + cgc_pkg::CNT_W'(cgc_pkg::HALF_NODES);
  assign full      = alloc_index >= hi;
  assign oom       = full || (alloc_index >= cgc_pkg::CNT_W'(cgc_pkg::HEAP_NODES));
  assign scan_more = (scan < alloc_index) &&
                     (scan < cgc_pkg::CNT_W'(cgc_pkg::HEAP_NODES));
  assign new_addr  = cgc_pkg::ADDR_W'(alloc_index) + cgc_pkg::ADDR_W'(cgc_pkg::ADDR_BASE);

  assign busy       = state != S_IDLE;
  assign done_valid = state == S_DONE;
  assign done_data  = rslt;

  cgc_ptr u_ptr (
    .addr (ptr_addr),
    .lo   (lo),
    .res  (p)
  );

  always_comb begin
    case (state)
      S_EXEC:    ptr_addr = t;
      S_FWD_CHK: ptr_addr = rdata.left;
      default:   ptr_addr = fa;
    endcase
  end

  always_comb begin
    mem = '0;
    case (state)
      S_EXEC: begin
        if (t != '0 && p.in_heap) begin
          if (cmd == cgc_pkg::CMD_READ) begin
            mem.re    = 1'b1;
            mem.raddr = p.idx;
          end else if (cmd == cgc_pkg::CMD_WRITE) begin
            mem.we    = 1'b1;
            mem.waddr = p.idx;
            mem.wdata = '{value: val, left: l, right: r};
          end
        end
      end
      S_ALLOC: begin
        if (!oom) begin
          mem.we    = 1'b1;
          mem.waddr = alloc_index[cgc_pkg::IDX_W-1:0];
          mem.wdata = '{value: val, left: l, right: r};
        end
      end
      S_FWD_START: begin
        if (p.in_heap) begin
          mem.re    = 1'b1;
          mem.raddr = p.idx;
        end
      end
      S_FWD_CHK: begin
        if (!p.in_half && !full) begin
          mem.we    = 1'b1;
          mem.waddr = alloc_index[cgc_pkg::IDX_W-1:0];
          mem.wdata = rdata;
        end
      end
      S_FWD_MARK: begin
        mem.we    = 1'b1;
        mem.waddr = fidx;
        mem.wdata = '{value: rdata.value, left: new_addr, right: rdata.right};
      end
      S_FWD_RET: begin
        if (fret == RET_SCANL || fret == RET_SCANR) begin
          mem.re    = 1'b1;
          mem.raddr = scan[cgc_pkg::IDX_W-1:0];
        end
      end
      S_SCAN_CHK: begin
        if (scan_more) begin
          mem.re    = 1'b1;
          mem.raddr = scan[cgc_pkg::IDX_W-1:0];
        end
      end
      S_SL_WR: begin
        mem.we    = 1'b1;
        mem.waddr = scan[cgc_pkg::IDX_W-1:0];
        mem.wdata = '{value: rdata.value, left: fres, right: rdata.right};
      end
      S_SR_WR: begin
        mem.we    = 1'b1;
        mem.waddr = scan[cgc_pkg::IDX_W-1:0];
        mem.wdata = '{value: rdata.value, left: rdata.left, right: fres};
      end
      default: begin
        mem = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      alloc_index <= '0;
      active_half <= 1'b0;
      root_addr   <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            cmd   <= in_data.cmd;
            val   <= in_data.node_value;
            l     <= in_data.left_addr;
            r     <= in_data.right_addr;
            t     <= in_data.target_addr;
            rslt  <= '0;
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          case (cmd)
            cgc_pkg::CMD_ALLOC: begin
              state <= full ? S_GC_START : S_ALLOC;
            end
            cgc_pkg::CMD_READ, cgc_pkg::CMD_WRITE: begin
              if (t == '0) begin
                rslt.status <= cgc_pkg::ST_NULL;
                state       <= S_DONE;
              end else if (!p.in_heap) begin
                rslt.status <= cgc_pkg::ST_SEGV;
                state       <= S_DONE;
              end else begin
                state <= (cmd == cgc_pkg::CMD_READ) ? S_RD_WAIT : S_DONE;
              end
            end
            cgc_pkg::CMD_ROOT: begin
              root_addr <= t;
              state     <= S_DONE;
            end
            cgc_pkg::CMD_COLLECT: begin
              state <= S_GC_START;
            end
            default: begin
              state <= S_DONE;
            end
          endcase
        end
        S_RD_WAIT: begin
          rslt.out_value <= rdata.value;
          rslt.out_left  <= rdata.left;
          rslt.out_right <= rdata.right;
          state          <= S_DONE;
        end
        S_GC_START: begin
          active_half <= ~active_half;
          alloc_index <= lo_swap;
          scan        <= lo_swap;
          fa          <= root_addr;
          fret        <= RET_ROOT;
          state       <= S_FWD_START;
        end
        S_FWD_START: begin
          if (!p.in_heap) begin
            fres  <= fa;
            state <= S_FWD_RET;
          end else begin
            fidx  <= p.idx;
            state <= S_FWD_CHK;
          end
        end
        S_FWD_CHK: begin
          if (p.in_half) begin
            fres  <= rdata.left;
            state <= S_FWD_RET;
          end else if (full) begin
            fres  <= fa;
            state <= S_FWD_RET;
          end else begin
            state <= S_FWD_MARK;
          end
        end
        S_FWD_MARK: begin
          fres        <= new_addr;
          alloc_index <= alloc_index + 1'b1;
          state       <= S_FWD_RET;
        end
        S_FWD_RET: begin
          case (fret)
            RET_ROOT: begin
              root_addr <= fres;
              if (cmd == cgc_pkg::CMD_ALLOC) begin
                fa    <= l;
                fret  <= RET_L;
                state <= S_FWD_START;
              end else begin
                state <= S_SCAN_CHK;
              end
            end
            RET_L: begin
              l     <= fres;
              fa    <= r;
              fret  <= RET_R;
              state <= S_FWD_START;
            end
            RET_R: begin
              r     <= fres;
              state <= S_SCAN_CHK;
            end
            RET_SCANL: begin
              state <= S_SL_WR;
            end
            RET_SCANR: begin
              state <= S_SR_WR;
            end
            default: begin
              state <= S_SCAN_CHK;
            end
          endcase
        end
        S_SCAN_CHK: begin
          if (scan_more) begin
            state <= S_SCAN_RD;
          end else begin
            state <= (cmd == cgc_pkg::CMD_ALLOC) ? S_ALLOC : S_DONE;
          end
        end
        S_SCAN_RD: begin
          fa    <= rdata.left;
          fret  <= RET_SCANL;
          state <= S_FWD_START;
        end
        S_SL_WR: begin
          fa    <= rdata.right;
          fret  <= RET_SCANR;
          state <= S_FWD_START;
        end
        S_SR_WR: begin
          scan  <= scan + 1'b1;
          state <= S_SCAN_CHK;
        end
        S_ALLOC: begin
          if (oom) begin
            rslt.status <= cgc_pkg::ST_OOM;
          end else begin
            rslt.result_addr <= new_addr;
            alloc_index      <= alloc_index + 1'b1;
          end
          state <= S_DONE;
        end
        S_DONE: begin
          if (done_ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: rtl/cgc_check.sv
module cgc_check (
  input logic          clk,
  input logic          rst,
  input logic          in_valid,
  input logic          in_stall,
  input cgc_pkg::in_t  in_data,
  input logic          out_valid,
  input logic          out_stall,
  input cgc_pkg::out_t out_data
);

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !in_stall && !out_valid)
    else $error("block not idle after reset");

  a_busy_after_transfer: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input not stalled while item in work");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed or dropped");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.status != cgc_pkg::ST_OK |->
      out_data.result_addr == '0 && out_data.out_value == '0 &&
      out_data.out_left == '0 && out_data.out_right == '0)
    else $error("error result carries data");

  a_alloc_addr: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.result_addr != '0 |->
      out_data.status == cgc_pkg::ST_OK &&
      out_data.result_addr >= cgc_pkg::ADDR_W'(cgc_pkg::ADDR_BASE) &&
      out_data.result_addr <
        cgc_pkg::ADDR_W'(cgc_pkg::ADDR_BASE + cgc_pkg::HEAP_NODES))
    else $error("allocated address outside heap");

endmodule

bind copying_garbage_collector cgc_check u_cgc_check (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

FILE: dv/cgc_checker.sv
module cgc_checker
  import cgc_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  input  logic in_stall,
  input  in_t  in_data,
  input  logic out_valid,
  input  logic out_stall,
  input  out_t out_data,
  output int   fail_count,
  output int   replies_owed
);

  logic [VAL_W-1:0]  heap_value [HEAP_NODES];
  logic [ADDR_W-1:0] heap_left  [HEAP_NODES];
  logic [ADDR_W-1:0] heap_right [HEAP_NODES];
  int                next_free;
  bit                upper_half;
  logic [ADDR_W-1:0] root;
  out_t              replies_due [$];
  int                mismatches = 0;
  int                owed = 0;

  assign fail_count   = mismatches;
  assign replies_owed = owed;

  function automatic bit in_heap(input logic [ADDR_W-1:0] a);
    return int'(a) >= ADDR_BASE && int'(a) < ADDR_BASE + HEAP_NODES;
  endfunction

  function automatic int half_base();
    return upper_half ? HALF_NODES : 0;
  endfunction

  // Copy one node into to-space unless already forwarded; bad pointers pass through.
  function automatic logic [ADDR_W-1:0] forward(input logic [ADDR_W-1:0] a);
    int                lo;
    int                idx;
    int                fw;
    logic [ADDR_W-1:0] moved;
    lo = half_base();
    if (!in_heap(a)) return a;
    idx = int'(a) - ADDR_BASE;
    fw  = int'(heap_left[idx]);
    if (fw >= ADDR_BASE && fw - ADDR_BASE >= lo && fw - ADDR_BASE < lo + HALF_NODES)
      return heap_left[idx];
    if (next_free >= lo + HALF_NODES) return a;
    heap_value[next_free] = heap_value[idx];
    heap_left[next_free]  = heap_left[idx];
    heap_right[next_free] = heap_right[idx];
    moved = ADDR_W'(next_free + ADDR_BASE);
    heap_left[idx] = moved;
    next_free++;
    return moved;
  endfunction

  function automatic void run_collection(input bit with_operands,
                                         inout logic [ADDR_W-1:0] op_left,
                                         inout logic [ADDR_W-1:0] op_right);
    int scan;
    upper_half = !upper_half;
    scan       = half_base();
    next_free  = scan;
    root       = forward(root);
    if (with_operands) begin
      op_left  = forward(op_left);
      op_right = forward(op_right);
    end
    while (scan < next_free && scan < HEAP_NODES) begin
      heap_left[scan]  = forward(heap_left[scan]);
      heap_right[scan] = forward(heap_right[scan]);
      scan++;
    end
  endfunction

  function automatic out_t apply_heap_cmd(input in_t item);
    out_t              res;
    logic [ADDR_W-1:0] l;
    logic [ADDR_W-1:0] r;
    int                idx;
    res = '0;
    l   = item.left_addr;
    r   = item.right_addr;
    case (item.cmd)
      CMD_ALLOC: begin
        if (next_free >= half_base() + HALF_NODES) run_collection(1'b1, l, r);
        if (next_free >= half_base() + HALF_NODES || next_free >= HEAP_NODES) begin
          res.status = ST_OOM;
        end else begin
          heap_value[next_free] = item.node_value;
          heap_left[next_free]  = l;
          heap_right[next_free] = r;
          res.result_addr       = ADDR_W'(next_free + ADDR_BASE);
          next_free++;
        end
      end
      CMD_READ, CMD_WRITE: begin
        if (item.target_addr == '0) begin
          res.status = ST_NULL;
        end else if (!in_heap(item.target_addr)) begin
          res.status = ST_SEGV;
        end else begin
          idx = int'(item.target_addr) - ADDR_BASE;
          if (item.cmd == CMD_READ) begin
            res.out_value = heap_value[idx];
            res.out_left  = heap_left[idx];
            res.out_right = heap_right[idx];
          end else begin
            heap_value[idx] = item.node_value;
            heap_left[idx]  = item.left_addr;
            heap_right[idx] = item.right_addr;
          end
        end
      end
      CMD_ROOT: root = item.target_addr;
      CMD_COLLECT: run_collection(1'b0, l, r);
      default: ;
    endcase
    return res;
  endfunction

  task automatic check_field(input string name, input int exp, input int act);
    if (exp != act) begin
      $error("%s expected %0d actual %0d", name, exp, act);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    out_t exp;
    if (rst) begin
      next_free  = 0;
      upper_half = 1'b0;
      root       = '0;
      replies_due.delete();
    end else begin
      if (in_valid && !in_stall) replies_due.push_back(apply_heap_cmd(in_data));
      if (out_valid && !out_stall) begin
        if (replies_due.size() == 0) begin
          $error("unexpected result transfer, status %0d", out_data.status);
          mismatches++;
        end else begin
          exp = replies_due.pop_front();
          check_field("status", exp.status, out_data.status);
          check_field("result_addr", exp.result_addr, out_data.result_addr);
          check_field("out_value", exp.out_value, out_data.out_value);
          check_field("out_left", exp.out_left, out_data.out_left);
          check_field("out_right", exp.out_right, out_data.out_right);
        end
      end
    end
    owed = replies_due.size();
  end

endmodule

FILE: dv/testbench.sv
module testbench;
  import cgc_pkg::*;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_stall;
  in_t  in_data;
  logic out_valid;
  logic out_stall;
  out_t out_data;
  int   fail_count;
  int   replies_owed;
  int   send_idle_pct = 0;
  int   recv_stall_pct = 0;
  bit   hold_off = 1'b0;

  copying_garbage_collector u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  cgc_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data      (in_data),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_data     (out_data),
    .fail_count   (fail_count),
    .replies_owed (replies_owed)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #24000000;
    $display("simulation failed");
    $finish;
  end

  // Hold off the result side for a long stretch once pressure is requested.
  initial begin
    int held;
    held = 0;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off && held < 80) begin
        out_stall <= 1'b1;
        held++;
      end else begin
        out_stall <= $urandom_range(99) < recv_stall_pct;
      end
    end
  end

  function automatic in_t make_cmd(input logic [2:0] cmd, input logic [VAL_W-1:0] val,
                                   input logic [ADDR_W-1:0] l, input logic [ADDR_W-1:0] r,
                                   input logic [ADDR_W-1:0] t);
    in_t item;
    item.cmd         = cmd;
    item.node_value  = val;
    item.left_addr   = l;
    item.right_addr  = r;
    item.target_addr = t;
    return item;
  endfunction

  function automatic logic [ADDR_W-1:0] pick_addr();
    int sel;
    sel = $urandom_range(99);
    if (sel < 8) return '0;
    if (sel < 16) return ADDR_W'($urandom_range(4095));
    if (sel < 18) return ADDR_W'(ADDR_BASE - 1);
    if (sel < 20) return ADDR_W'(ADDR_BASE + HEAP_NODES);
    return ADDR_W'(ADDR_BASE + $urandom_range(HEAP_NODES - 1));
  endfunction

  function automatic logic [ADDR_W-1:0] pick_bad_addr();
    case ($urandom_range(3))
      0: return '0;
      1: return ADDR_W'(ADDR_BASE - 1);
      2: return ADDR_W'(ADDR_BASE + HEAP_NODES);
      default: return ADDR_W'($urandom_range(4095, ADDR_BASE + HEAP_NODES));
    endcase
  endfunction

  function automatic in_t random_item();
    in_t item;
    int  pick;
    item = make_cmd(CMD_ALLOC, VAL_W'($urandom_range(255)), pick_addr(), pick_addr(),
                    pick_addr());
    pick = $urandom_range(99);
    if (pick < 42) begin
      item.cmd = CMD_ALLOC;
    end else if (pick < 60) begin
      item.cmd = CMD_READ;
    end else if (pick < 72) begin
      item.cmd = CMD_WRITE;
    end else if (pick < 84) begin
      item.cmd = CMD_ROOT;
      if ($urandom_range(2) == 0) item.target_addr = '0;
    end else if (pick < 94) begin
      item.cmd = CMD_COLLECT;
    end else begin
      item.cmd = 3'($urandom_range(7, 5));
    end
    return item;
  endfunction

  task automatic issue(input in_t item);
    bit taken;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk);
      taken = !in_stall;
      @(posedge clk);
    end
  endtask

  task automatic run_phase(input int count, input int idle_pct, input int stall_pct);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (count) issue(random_item());
  endtask

  initial begin
    rst      = 1'b1;
    in_valid = 1'b0;
    in_data  = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Fill every heap entry so no later access touches an unwritten node.
    for (int i = 0; i < HEAP_NODES; i++)
      issue(make_cmd(CMD_WRITE, VAL_W'($urandom_range(255)), pick_addr(), pick_addr(),
                     ADDR_W'(ADDR_BASE + i)));

    // Chain a full half from the root, then allocate: collection fills to-space, out of memory.
    for (int i = 0; i < HALF_NODES; i++)
      issue(make_cmd(CMD_ALLOC, VAL_W'($urandom_range(255)),
                     (i == 0) ? '0 : ADDR_W'(ADDR_BASE + i - 1),
                     pick_bad_addr(), ADDR_W'($urandom_range(4095))));
    issue(make_cmd(CMD_ROOT, '0, '0, '0, ADDR_W'(ADDR_BASE + HALF_NODES - 1)));
    issue(make_cmd(CMD_ALLOC, 8'h5A, ADDR_W'(ADDR_BASE + 3), ADDR_W'(ADDR_BASE + 40), '0));
    issue(make_cmd(CMD_COLLECT, '0, '0, '0, '0));

    issue(make_cmd(CMD_ROOT, '0, '0, '0, '0));
    issue(make_cmd(CMD_COLLECT, '0, '0, '0, '0));
    issue(make_cmd(CMD_ALLOC, 8'hFF, 12'hFFF, 12'hFFF, 12'hFFF));
    issue(make_cmd(CMD_ALLOC, 8'h00, '0, '0, '0));
    issue(make_cmd(CMD_READ, '0, '0, '0, '0));
    issue(make_cmd(CMD_READ, '0, '0, '0, ADDR_W'(ADDR_BASE - 1)));
    issue(make_cmd(CMD_READ, '0, '0, '0, ADDR_W'(ADDR_BASE + HEAP_NODES)));
    issue(make_cmd(CMD_READ, '0, '0, '0, 12'hFFF));
    issue(make_cmd(CMD_READ, '0, '0, '0, ADDR_W'(ADDR_BASE)));
    issue(make_cmd(CMD_READ, '0, '0, '0, ADDR_W'(ADDR_BASE + HEAP_NODES - 1)));
    issue(make_cmd(CMD_WRITE, 8'h11, ADDR_W'(ADDR_BASE), ADDR_W'(ADDR_BASE), '0));
    issue(make_cmd(CMD_WRITE, 8'h22, ADDR_W'(ADDR_BASE), ADDR_W'(ADDR_BASE), 12'hFFF));
    issue(make_cmd(CMD_WRITE, 8'hFF, 12'hFFF, '0, ADDR_W'(ADDR_BASE + HEAP_NODES - 1)));
    issue(make_cmd(CMD_READ, '0, '0, '0, ADDR_W'(ADDR_BASE + HEAP_NODES - 1)));
    issue(make_cmd(CMD_ROOT, '0, '0, '0, 12'hFFF));
    issue(make_cmd(CMD_COLLECT, '0, '0, '0, '0));
    issue(make_cmd(CMD_ROOT, '0, '0, '0, ADDR_W'(ADDR_BASE)));
    issue(make_cmd(CMD_COLLECT, '0, '0, '0, '0));
    issue(make_cmd(3'd5, 8'hFF, 12'hFFF, 12'hFFF, 12'hFFF));
    issue(make_cmd(3'd6, 8'hFF, 12'hFFF, 12'hFFF, 12'hFFF));
    issue(make_cmd(3'd7, 8'hFF, 12'hFFF, 12'hFFF, 12'hFFF));
    issue(make_cmd(CMD_ALLOC, 8'hAA, ADDR_W'(ADDR_BASE), ADDR_W'(ADDR_BASE + HEAP_NODES - 1),
                   '0));

    run_phase(96, 0, 0);
    run_phase(96, 82, 0);
    run_phase(96, 0, 82);
    run_phase(96, 17, 17);
    hold_off = 1'b1;
    run_phase(96, 0, 0);
    in_valid <= 1'b0;

    do @(negedge clk); while (replies_owed != 0);
    repeat (20) @(posedge clk);
    if (fail_count == 0 && replies_owed == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
